@@ rtl/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg
// Shared widths, codes and pipeline types of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

	// Operand word and fraction widths (signed Q8.8 by default).
	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 8;

	// Full product width and the width of the scaled dividend remainder.
	localparam int PW         = 2 * DATA_WIDTH;
	localparam int EW         = 3 * DATA_WIDTH + FRAC_BITS;
	localparam int SHW        = $clog2(DATA_WIDTH + 1);
	localparam int DIV_STAGES = DATA_WIDTH + 1;
	localparam int N_STAGES   = DIV_STAGES + 3;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_SAT = 2'd1,
		ST_DZ  = 2'd2
	} status_t;

	// One result part in sign-magnitude form: big marks a magnitude of at
	// least 2^DATA_WIDTH, rem is the running remainder of a division.
	typedef struct packed {
		logic                  neg;
		logic                  big;
		logic [DATA_WIDTH-1:0] q;
		logic [EW-1:0]         rem;
	} part_t;

	typedef struct packed {
		logic          is_div;
		logic          dz;
		logic [PW-1:0] den;
		part_t         re;
		part_t         im;
	} dpipe_t;

endpackage

@@ rtl/cau_front.sv @@
// ----------------------------------------------------------------------------
// cau_front
// First two pipeline stages: products and sums, then sign-magnitude parts
// and the squared divisor magnitude.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
	input  logic                         clk,
	input  logic                         en,
	input  logic [1:0]                   req_type,
	input  logic signed [DATA_WIDTH-1:0] a_re,
	input  logic signed [DATA_WIDTH-1:0] a_im,
	input  logic signed [DATA_WIDTH-1:0] b_re,
	input  logic signed [DATA_WIDTH-1:0] b_im,
	output dpipe_t                       d_out
);

	op_t                        op_s1;
	logic signed [PW-1:0]       prr_s1, pii_s1, pri_s1, pir_s1;
	logic [PW-1:0]              sqr_s1, sqi_s1;
	logic signed [DATA_WIDTH:0] sre_s1, sim_s1;

	logic signed [DATA_WIDTH:0] are_x, aim_x, bre_x, bim_x;
	logic signed [PW-1:0]       sqr_p, sqi_p;
	logic signed [PW:0]         num_re, num_im;
	dpipe_t                     d_c;

	// Builds one part from the sum (add, subtract) or the numerator.
	function automatic part_t make_part(op_t op, logic signed [DATA_WIDTH:0] s,
			logic signed [PW:0] n);
		logic [DATA_WIDTH:0] sa;
		logic [PW:0]         na;
		logic [PW:0]         ns;
		part_t               p;
		sa = s[DATA_WIDTH] ? (~s + 1'b1) : s;
		na = n[PW] ? (~n + 1'b1) : n;
		ns = na >> FRAC_BITS;
		p  = '0;
		case (op)
			OP_ADD, OP_SUB: begin
				p.neg = s[DATA_WIDTH];
				p.big = sa[DATA_WIDTH];
				p.q   = sa[DATA_WIDTH-1:0];
			end
			OP_MUL: begin
				p.neg = n[PW];
				p.big = |ns[PW:DATA_WIDTH];
				p.q   = ns[DATA_WIDTH-1:0];
			end
			default: begin
				p.neg = n[PW];
				p.rem = EW'(na) << FRAC_BITS;
			end
		endcase
		return p;
	endfunction

	// Stage one: the six products and the two sums.
	assign are_x = {a_re[DATA_WIDTH-1], a_re};
	assign aim_x = {a_im[DATA_WIDTH-1], a_im};
	assign bre_x = {b_re[DATA_WIDTH-1], b_re};
	assign bim_x = {b_im[DATA_WIDTH-1], b_im};
	assign sqr_p = PW'(b_re) * PW'(b_re);
	assign sqi_p = PW'(b_im) * PW'(b_im);

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= op_t'(req_type);
			prr_s1 <= PW'(a_re) * PW'(b_re);
			pii_s1 <= PW'(a_im) * PW'(b_im);
			pri_s1 <= PW'(a_re) * PW'(b_im);
			pir_s1 <= PW'(a_im) * PW'(b_re);
			sqr_s1 <= $unsigned(sqr_p);
			sqi_s1 <= $unsigned(sqi_p);
			if (req_type == OP_SUB) begin
				sre_s1 <= are_x - bre_x;
				sim_s1 <= aim_x - bim_x;
			end else begin
				sre_s1 <= are_x + bre_x;
				sim_s1 <= aim_x + bim_x;
			end
		end
	end

	// Stage two: cross sums, magnitudes and the divisor.
	always_comb begin
		if (op_s1 == OP_DIV) begin
			num_re = {prr_s1[PW-1], prr_s1} + {pii_s1[PW-1], pii_s1};
			num_im = {pir_s1[PW-1], pir_s1} - {pri_s1[PW-1], pri_s1};
		end else begin
			num_re = {prr_s1[PW-1], prr_s1} - {pii_s1[PW-1], pii_s1};
			num_im = {pri_s1[PW-1], pri_s1} + {pir_s1[PW-1], pir_s1};
		end
		d_c.is_div = (op_s1 == OP_DIV);
		d_c.den    = sqr_s1 + sqi_s1;
		d_c.dz     = d_c.is_div && (d_c.den == '0);
		d_c.re     = make_part(op_s1, sre_s1, num_re);
		d_c.im     = make_part(op_s1, sim_s1, num_im);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= d_c;
		end
	end

endmodule

@@ rtl/cau_dstage.sv @@
// ----------------------------------------------------------------------------
// cau_dstage
// One restoring division step for both parts; the step at the top bit
// position only detects a quotient too large to represent.
// ----------------------------------------------------------------------------
module cau_dstage import cau_pkg::*; (
	input  logic           clk,
	input  logic           en,
	input  logic [SHW-1:0] sh,
	input  dpipe_t         d_in,
	output dpipe_t         d_out
);

	logic [EW-1:0]         sub;
	logic [DATA_WIDTH-1:0] qbit;
	logic                  top;
	dpipe_t                d_c;

	function automatic part_t step(part_t p, logic [EW-1:0] s,
			logic [DATA_WIDTH-1:0] m, logic t);
		part_t r;
		r = p;
		if (p.rem >= s) begin
			r.rem = p.rem - s;
			if (t) begin
				r.big = 1'b1;
			end else begin
				r.q = p.q | m;
			end
		end
		return r;
	endfunction

	// Shifted divisor and the quotient bit this step decides.
	assign sub  = EW'(d_in.den) << sh;
	assign qbit = DATA_WIDTH'(1) << sh;
	assign top  = (sh == SHW'(DATA_WIDTH));

	always_comb begin
		d_c = d_in;
		if (d_in.is_div) begin
			d_c.re = step(d_in.re, sub, qbit, top);
			d_c.im = step(d_in.im, sub, qbit, top);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= d_c;
		end
	end

endmodule

@@ rtl/cau_pack.sv @@
// ----------------------------------------------------------------------------
// cau_pack
// Output stage: saturation to the signed word range, division-by-zero
// handling and the status code.
// ----------------------------------------------------------------------------
module cau_pack import cau_pkg::*; (
	input  logic                         clk,
	input  logic                         en,
	input  dpipe_t                       d_in,
	output logic signed [DATA_WIDTH-1:0] res_re,
	output logic signed [DATA_WIDTH-1:0] res_im,
	output logic [1:0]                   status
);

	logic [DATA_WIDTH-1:0] re_v, im_v;
	logic                  re_sat, im_sat;

	// Clamps one part and returns it in two's complement.
	function automatic logic [DATA_WIDTH:0] clamp(part_t p);
		logic                  zero;
		logic                  neg;
		logic [DATA_WIDTH-1:0] lim;
		logic                  sat;
		logic [DATA_WIDTH-1:0] m;
		zero = !p.big && (p.q == '0);
		neg  = p.neg && !zero;
		lim  = {1'b0, {(DATA_WIDTH-1){1'b1}}} + DATA_WIDTH'(neg);
		sat  = p.big || (p.q > lim);
		m    = sat ? lim : p.q;
		return {sat, neg ? (~m + 1'b1) : m};
	endfunction

	always_comb begin
		{re_sat, re_v} = clamp(d_in.re);
		{im_sat, im_v} = clamp(d_in.im);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (d_in.dz) begin
				res_re <= '0;
				res_im <= '0;
				status <= ST_DZ;
			end else begin
				res_re <= re_v;
				res_im <= im_v;
				status <= (re_sat || im_sat) ? ST_SAT : ST_OK;
			end
		end
	end

endmodule

@@ rtl/complex_arith_unit.sv @@
// ----------------------------------------------------------------------------
// complex_arith_unit
// Complex add, subtract, multiply and divide in signed Q8.8 fixed point.
// ----------------------------------------------------------------------------
// The unit takes one item per cycle while it is not stalled. Two stages form
// products and sums, DATA_WIDTH + 1 restoring divider stages check overflow
// and decide the quotient bits one per stage, and one stage saturates. Every
// operation goes through the same pipeline, so results leave in the order in
// which items came in. When the result is stalled the whole pipeline holds
// and in_stall is raised.
module complex_arith_unit import cau_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   req_type,
	input  logic signed [DATA_WIDTH-1:0] a_re,
	input  logic signed [DATA_WIDTH-1:0] a_im,
	input  logic signed [DATA_WIDTH-1:0] b_re,
	input  logic signed [DATA_WIDTH-1:0] b_im,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] res_re,
	output logic signed [DATA_WIDTH-1:0] res_im,
	output logic [1:0]                   status
);

	logic                en;
	logic [N_STAGES-1:0] vld_q;
	dpipe_t              dch [DIV_STAGES+1];

	// The pipeline moves whenever the output is free or taken.
	assign en        = !(vld_q[N_STAGES-1] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[N_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[N_STAGES-2:0], in_valid};
		end
	end

	cau_front u_front (
		.clk      (clk),
		.en       (en),
		.req_type (req_type),
		.a_re     (a_re),
		.a_im     (a_im),
		.b_re     (b_re),
		.b_im     (b_im),
		.d_out    (dch[0])
	);

	// Divider steps from the overflow check down to quotient bit zero.
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		cau_dstage u_dstage (
			.clk   (clk),
			.en    (en),
			.sh    (SHW'(DATA_WIDTH - g)),
			.d_in  (dch[g]),
			.d_out (dch[g+1])
		);
	end

	cau_pack u_pack (
		.clk    (clk),
		.en     (en),
		.d_in   (dch[DIV_STAGES]),
		.res_re (res_re),
		.res_im (res_im),
		.status (status)
	);

`ifndef ASSERT_OFF
	// A division by zero always gives a zero result.
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DZ |-> res_re == '0 && res_im == '0)
		else $error("division by zero gave a nonzero result");

	// A saturated status means at least one part sits at a range limit.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_SAT |->
			res_re == {1'b0, {(DATA_WIDTH-1){1'b1}}} ||
			res_re == {1'b1, {(DATA_WIDTH-1){1'b0}}} ||
			res_im == {1'b0, {(DATA_WIDTH-1){1'b1}}} ||
			res_im == {1'b1, {(DATA_WIDTH-1){1'b0}}})
		else $error("saturation flagged without a limit value");

	// An accepted item is marked valid in the first stage register.
	a_vld_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_q[0])
		else $error("accepted item lost at pipeline entry");
`endif

endmodule
